FILE: rtl/tspq_pkg.sv
// Shared types and constants for the three-level stable priority queue.
`default_nettype none

package tspq_pkg;

    localparam int NUM_LEVELS  = 3;
    localparam int ID_FIELD_W  = 16;
    localparam int LEVEL_W     = 2;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 3;

    localparam logic ACT_ADMIT = 1'b0;
    localparam logic ACT_SERVE = 1'b1;

    typedef enum logic [2:0] {
        ST_ADMITTED  = 3'd0,
        ST_SERVED    = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_LEVEL = 3'd4
    } status_t;

    // One request as it travels down the row of level cells.
    typedef struct packed {
        logic                  valid;
        logic                  action;
        logic [LEVEL_W-1:0]    level;
        logic [ID_FIELD_W-1:0] entry_id;
        logic                  done;
        status_t               status;
        logic [LEVEL_W-1:0]    served_level;
    } token_t;

endpackage

`default_nettype wire

FILE: rtl/tspq_store.sv
// Shared entry store: one write or one registered read per cycle.
`default_nettype none

module tspq_store #(
    parameter int DEPTH  = 192,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata_reg
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tspq_cell.sv
// One level cell: keeps head, tail and count of its level and claims passing requests.
`default_nettype none

module tspq_cell import tspq_pkg::*; #(
    parameter int LEVEL_DEPTH = 64,
    parameter int LEVEL_NUM   = 1,
    parameter int ADDR_W      = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire token_t            tok_in,
    output token_t                 tok_out_reg,
    output logic                   mem_we,
    output logic                   mem_re,
    output logic      [ADDR_W-1:0] mem_addr
);

    localparam int SLOT_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam logic [ADDR_W-1:0]  BASE       = ADDR_W'((LEVEL_NUM - 1) * LEVEL_DEPTH);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(LEVEL_DEPTH - 1);
    localparam logic [CNT_W-1:0]   FULL_CNT   = CNT_W'(LEVEL_DEPTH);
    localparam logic [LEVEL_W-1:0] LEVEL_CODE = LEVEL_W'(LEVEL_NUM);

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    token_t            tok_next;
    logic              hit_admit;
    logic              hit_serve;

    assign hit_admit = tok_in.valid && !tok_in.done && (tok_in.action == ACT_ADMIT)
                       && (tok_in.level == LEVEL_CODE);
    assign hit_serve = tok_in.valid && !tok_in.done && (tok_in.action == ACT_SERVE)
                       && (count_reg != '0);

    always_comb begin
        tok_next   = tok_in;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = '0;
        if (hit_admit) begin
            tok_next.done = 1'b1;
            if (count_reg == FULL_CNT) begin
                tok_next.status = ST_FULL;
            end else begin
                mem_we          = 1'b1;
                mem_addr        = BASE + ADDR_W'(tail_reg);
                tail_next       = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                count_next      = count_reg + 1'b1;
                tok_next.status = ST_ADMITTED;
            end
        end else if (hit_serve) begin
            mem_re                = 1'b1;
            mem_addr              = BASE + ADDR_W'(head_reg);
            head_next             = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
            count_next            = count_reg - 1'b1;
            tok_next.done         = 1'b1;
            tok_next.status       = ST_SERVED;
            tok_next.served_level = LEVEL_CODE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_out_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
        end else begin
            tok_out_reg <= tok_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/three_level_stable_priority_queue_core.sv
// Top level of the three-level stable priority queue.
//
//  Channel | Direction | tdata (low bit up)                    | tuser
//  s_      | in        | level[1:0], entry_id[17:2], zero pad  | action[0]
//  m_      | out       | served_id[15:0], served_level[17:16]  | status[2:0]
//
// A request passes an entry register, one cell per level, a result register and the output
// register, in that order, before its result shows on m_.
// The row of level cells holds one request at a time; a new input transaction is taken once
// the previous result has moved into the output register.
// A synchronous low aresetn empties all three levels; no clearing pass is needed.
// A stalled m_ side holds the result; the next request is still taken behind it.
`default_nettype none

module three_level_stable_priority_queue_core import tspq_pkg::*; #(
    parameter int LEVEL_DEPTH = 64,
    parameter int ID_BITS     = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // level[1:0], entry_id[17:2], pad[23:18]
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // action[0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // served_id[15:0], served_level[17:16], pad
    output logic      [M_TUSER_W-1:0] m_tuser    // status[2:0]
);

    localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    token_t tok_chain [0:NUM_LEVELS];
    token_t tok_in_reg, tok_in_next;
    token_t tok_last;

    logic              cell_we   [0:NUM_LEVELS-1];
    logic              cell_re   [0:NUM_LEVELS-1];
    logic [ADDR_W-1:0] cell_addr [0:NUM_LEVELS-1];

    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_addr;
    logic [ID_FIELD_W-1:0] wr_id;
    logic [ID_BITS-1:0]    mem_rdata;

    logic                  busy_reg, busy_next;
    logic                  res_valid_reg, res_valid_next;
    status_t               res_status_reg, res_status_next;
    logic [ID_FIELD_W-1:0] res_id_reg, res_id_next;
    logic [LEVEL_W-1:0]    res_level_reg, res_level_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TUSER_W-1:0]  m_tuser_reg;

    logic accept;
    logic move_out;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign move_out = res_valid_reg && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        tok_in_next              = '0;
        tok_in_next.valid        = accept;
        tok_in_next.action       = s_tuser[0];
        tok_in_next.level        = s_tdata[LEVEL_W-1:0];
        tok_in_next.entry_id     = s_tdata[LEVEL_W+ID_FIELD_W-1:LEVEL_W];
        tok_in_next.status       = ST_EMPTY;
    end

    assign tok_chain[0] = tok_in_reg;

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cell
        tspq_cell #(
            .LEVEL_DEPTH (LEVEL_DEPTH),
            .LEVEL_NUM   (g + 1),
            .ADDR_W      (ADDR_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .tok_in      (tok_chain[g]),
            .tok_out_reg (tok_chain[g+1]),
            .mem_we      (cell_we[g]),
            .mem_re      (cell_re[g]),
            .mem_addr    (cell_addr[g])
        );
    end

    // Only one request is in the row, so at most one cell asks for the store.
    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = '0;
        wr_id    = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (cell_we[i] || cell_re[i]) begin
                mem_addr = cell_addr[i];
            end
            if (cell_we[i]) begin
                mem_we = 1'b1;
                wr_id  = tok_chain[i].entry_id;
            end
            if (cell_re[i]) begin
                mem_re = 1'b1;
            end
        end
    end

    tspq_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ID_BITS)
    ) u_store (
        .aclk      (aclk),
        .we        (mem_we),
        .re        (mem_re),
        .addr      (mem_addr),
        .wdata     (ID_BITS'(wr_id)),
        .rdata_reg (mem_rdata)
    );

    assign tok_last = tok_chain[NUM_LEVELS];

    // The store read has finished no later than the edge at which the request leaves the last cell.
    always_comb begin
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_level_next  = res_level_reg;
        if (tok_last.valid) begin
            res_valid_next = 1'b1;
            if (tok_last.done) begin
                res_status_next = tok_last.status;
            end else if (tok_last.action == ACT_SERVE) begin
                res_status_next = ST_EMPTY;
            end else begin
                res_status_next = ST_BAD_LEVEL;
            end
            if (tok_last.done && (tok_last.status == ST_SERVED)) begin
                res_id_next    = ID_FIELD_W'(mem_rdata);
                res_level_next = tok_last.served_level;
            end else begin
                res_id_next    = '0;
                res_level_next = '0;
            end
        end else if (move_out) begin
            res_valid_next = 1'b0;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (move_out) begin
            busy_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (move_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_in_reg    <= '0;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            tok_in_reg    <= tok_in_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_level_reg  <= res_level_next;
        if (move_out) begin
            m_tdata_reg <= M_TDATA_W'({res_level_reg, res_id_reg});
            m_tuser_reg <= res_status_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tspq_checker.sv
// Port-level checks for the three-level stable priority queue, bound to the top level.
`default_nettype none

module tspq_checker import tspq_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    // One request at a time: an input transaction closes the input side for the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a request is still in the level cells");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_ADMITTED || m_tuser == ST_SERVED || m_tuser == ST_EMPTY
                      || m_tuser == ST_FULL || m_tuser == ST_BAD_LEVEL))
        else $error("result status out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_SERVED)) |-> (m_tdata == '0))
        else $error("served fields not zero on a non-serve result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_SERVED)) |-> (m_tdata[17:16] != 2'd0))
        else $error("served result carries level zero");

endmodule

bind three_level_stable_priority_queue_core tspq_checker u_tspq_checker (.*);

`default_nettype wire

FILE: tb/sv/tspq_scoreboard.sv
// Scoreboard that predicts and checks every result of the three-level stable priority queue.
module tspq_scoreboard import tspq_pkg::*; #(
    parameter int DEPTH   = 64,
    parameter int ID_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // level[1:0], entry_id[17:2], pad[23:18]
    input  logic [S_TUSER_W-1:0] s_tuser,   // action[0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // served_id[15:0], served_level[17:16], pad[23:18]
    input  logic [M_TUSER_W-1:0] m_tuser,   // status[2:0]
    output int                   mismatches,
    output int                   outstanding
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [ID_FIELD_W-1:0] ID_MASK = ID_FIELD_W'((64'd1 << ID_BITS) - 1);

    typedef struct {
        status_t               status;
        logic [ID_FIELD_W-1:0] id;
        logic [LEVEL_W-1:0]    lvl;
    } outcome_t;

    outcome_t              awaited_outcomes[$];
    logic [ID_FIELD_W-1:0] level_slots[NUM_LEVELS][DEPTH];
    logic [PW-1:0]         rd_ptr[NUM_LEVELS];
    logic [PW-1:0]         wr_ptr[NUM_LEVELS];
    logic [PW:0]           fill[NUM_LEVELS];

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Applies one request to the shadow queues and returns the result it must produce.
    function automatic outcome_t next_outcome(input logic act, input logic [LEVEL_W-1:0] lvl,
                                              input logic [ID_FIELD_W-1:0] id);
        outcome_t o;
        int       q;
        o.status = ST_EMPTY;
        o.id     = '0;
        o.lvl    = '0;
        if (act == ACT_ADMIT) begin
            if (lvl == '0) begin
                o.status = ST_BAD_LEVEL;
            end else begin
                q = int'(lvl) - 1;
                if (fill[q] == DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    level_slots[q][wr_ptr[q]] = id & ID_MASK;
                    wr_ptr[q] = bump(wr_ptr[q]);
                    fill[q]   = fill[q] + 1'b1;
                    o.status  = ST_ADMITTED;
                end
            end
        end else begin
            // The most urgent non-empty level gives up its oldest entry.
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (o.status == ST_EMPTY && fill[l] != 0) begin
                    o.id      = level_slots[l][rd_ptr[l]];
                    o.lvl     = LEVEL_W'(l + 1);
                    rd_ptr[l] = bump(rd_ptr[l]);
                    fill[l]   = fill[l] - 1'b1;
                    o.status  = ST_SERVED;
                end
            end
        end
        return o;
    endfunction

    always @(posedge aclk) begin : watch
        outcome_t want;
        if (!aresetn) begin
            awaited_outcomes.delete();
            mismatches = 0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                rd_ptr[l] = '0;
                wr_ptr[l] = '0;
                fill[l]   = '0;
            end
        end else begin
            // Results are checked before the same edge's request is predicted, so a result
            // can never be matched against a request taken at the same edge.
            if (m_tvalid && m_tready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result transaction with nothing expected: status %0d, id %h",
                           m_tuser, m_tdata[15:0]);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[15:0] !== want.id) begin
                        $error("served_id: expected %h, actual %h", want.id, m_tdata[15:0]);
                        mismatches++;
                    end
                    if (m_tdata[17:16] !== want.lvl) begin
                        $error("served_level: expected %0d, actual %0d", want.lvl,
                               m_tdata[17:16]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_outcomes.push_back(next_outcome(s_tuser[0], s_tdata[1:0],
                                                        s_tdata[17:2]));
            end
        end
        outstanding <= awaited_outcomes.size();
    end

endmodule

FILE: tb/sv/tb_three_level_stable_priority_queue_core.sv
// Testbench top: drives requests into the priority queue and gives the verdict.
module tb_three_level_stable_priority_queue_core;
    import tspq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int ID_BITS      = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 250;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int quiet_cycles    = 0;
    int mismatches;
    int outstanding;

    three_level_stable_priority_queue_core #(
        .LEVEL_DEPTH(DEPTH),
        .ID_BITS    (ID_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // level[1:0], entry_id[17:2], pad[23:18]
        .s_tuser (s_tuser),   // action[0]
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // served_id[15:0], served_level[17:16], pad[23:18]
        .m_tuser (m_tuser)    // status[2:0]
    );

    tspq_scoreboard #(
        .DEPTH  (DEPTH),
        .ID_BITS(ID_BITS)
    ) scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The run is declared hung once neither channel has moved a transaction for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request, idling first at the current rate; returns at the accepting edge.
    task automatic push_request(input logic act, input logic [LEVEL_W-1:0] lvl,
                                input logic [ID_FIELD_W-1:0] id);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, id, lvl};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int                    seg_left;
        int                    admit_pct;
        int                    focus;
        logic                  act;
        logic [LEVEL_W-1:0]    lvl;
        logic [ID_FIELD_W-1:0] id;
        seg_left  = 0;
        admit_pct = 50;
        focus     = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Serve on an empty queue, a bad level, then one mixed fill that must drain in
        // urgency order with arrival order kept inside each level.
        push_request(ACT_SERVE, 2'd3, 16'hFFFF);
        push_request(ACT_ADMIT, 2'd0, 16'hFFFF);
        push_request(ACT_ADMIT, 2'd3, 16'h0000);
        push_request(ACT_ADMIT, 2'd3, 16'hFFFF);
        push_request(ACT_ADMIT, 2'd2, 16'h5555);
        push_request(ACT_ADMIT, 2'd1, 16'hAAAA);
        push_request(ACT_ADMIT, 2'd2, 16'h1234);
        push_request(ACT_ADMIT, 2'd1, 16'h0001);
        push_request(ACT_ADMIT, 2'd0, 16'h0000);
        repeat (6) push_request(ACT_SERVE, 2'd0, 16'h0000);
        push_request(ACT_SERVE, 2'd1, 16'h8000);
        push_request(ACT_SERVE, 2'd0, 16'h0000);

        // Segments lean toward admits (to hit full levels and wrap), stay mixed, or lean toward serves
        // (to drain to empty), often focused on one level.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % PHASE_ITEMS == 0) begin
                case ((i / PHASE_ITEMS) % 4)
                    0: begin
                        sender_idle_pct = 0;
                        recv_stall_pct  = 0;
                    end
                    1: begin
                        sender_idle_pct = 57;
                        recv_stall_pct  = 0;
                    end
                    2: begin
                        sender_idle_pct = 0;
                        recv_stall_pct  = 57;
                    end
                    default: begin
                        sender_idle_pct = 37;
                        recv_stall_pct  = 37;
                    end
                endcase
            end
            if (i == RANDOM_ITEMS / 2) wait_drained();
            if (seg_left == 0) begin
                seg_left = $urandom_range(160, 40);
                case ($urandom_range(2))
                    0:       admit_pct = 92;
                    1:       admit_pct = 55;
                    default: admit_pct = 15;
                endcase
                focus = $urandom_range(3);
            end
            seg_left--;
            act = ($urandom_range(99) < admit_pct) ? ACT_ADMIT : ACT_SERVE;
            if ($urandom_range(99) < 4) begin
                lvl = 2'd0;
            end else if (focus != 0 && $urandom_range(99) < 70) begin
                lvl = LEVEL_W'(focus);
            end else begin
                lvl = LEVEL_W'($urandom_range(3, 1));
            end
            case ($urandom_range(9))
                0:       id = '0;
                1:       id = '1;
                default: id = ID_FIELD_W'($urandom);
            endcase
            push_request(act, lvl, id);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
